/* sv/agn_pkg.sv */
// Package for the gravity normalizer: payload structs, constants, helper widths.
// No dependencies; used by every module of the block.
`default_nettype none
package agn_pkg;
   localparam int DEF_WINDOW      = 10;
   // sample width taken from each axis field, at most 16 bits
   localparam int SAMPLE_BITS     = 16;
   localparam logic [15:0] GRAVITY_REF_RESET = 16'd16384;

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] scaled_x;
      logic signed [15:0] scaled_y;
      logic signed [15:0] scaled_z;
      logic               zero_average;
   } rsp_type;

   // Front-to-back queue entry: axis magnitudes with signs, plus window results.
   typedef struct packed {
      logic [2:0]  neg;
      logic [16:0] mag_x;
      logic [16:0] mag_y;
      logic [16:0] mag_z;
      logic [6:0]  fill;
      logic [22:0] sum;
   } job_type;
endpackage
`default_nettype wire

/* sv/agn_front.sv */
// Front part: takes samples, finds magnitude via iterative root, updates window.
// Depends on agn_pkg.
`default_nettype none
module agn_front import agn_pkg::*; #(
   parameter int WINDOW      = DEF_WINDOW
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         job_valid,
   input  wire logic    job_stall,
   output job_type      job_data
);
   localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [4:0] ROOT_STEPS = 5'd17;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ROOT = 2'd1;
   localparam logic [1:0] ST_WIN  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [2:0]  neg_ff, neg_in;
   logic [16:0] mag_ff [3];
   logic [16:0] mag_in [3];
   logic [35:0] rem_ff, rem_in;
   logic [35:0] root_ff, root_in;
   logic [35:0] bit_ff, bit_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [6:0]  fill_ff, fill_in;
   logic [22:0] sum_ff, sum_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [16:0] win_mem [WINDOW];
   logic [16:0] old_rd_ff;

   logic signed [SAMPLE_BITS-1:0] ax [3];
   logic [16:0] am [3];
   logic [35:0] sq;
   logic [35:0] trial;

   always_comb begin
      ax[0] = req_data.accel_x[SAMPLE_BITS-1:0];
      ax[1] = req_data.accel_y[SAMPLE_BITS-1:0];
      ax[2] = req_data.accel_z[SAMPLE_BITS-1:0];
      for (int i = 0; i < 3; i++) begin
         am[i] = ax[i][SAMPLE_BITS-1] ? 17'(-33'(ax[i])) : 17'(ax[i]);
      end
   end

   // sum of squares of the three axis magnitudes
   assign sq = 36'(am[0] * am[0]) + 36'(am[1] * am[1]) + 36'(am[2] * am[2]);
   assign trial = root_ff + bit_ff;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      cnt_in   = cnt_ff;
      fill_in  = fill_ff;
      sum_in   = sum_ff;
      slot_in  = slot_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = am[i];
                  neg_in[i] = ax[i][SAMPLE_BITS-1];
               end
               rem_in   = sq;
               root_in  = '0;
               bit_in   = 36'h4_0000_0000;
               cnt_in   = ROOT_STEPS;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (rem_ff >= trial) begin
               rem_in  = rem_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) state_in = ST_WIN;
         end
         ST_WIN: begin
            if (fill_ff >= 7'(WINDOW)) begin
               sum_in = sum_ff - 23'(old_rd_ff) + 23'(root_ff);
            end else begin
               fill_in = fill_ff + 7'd1;
               sum_in  = sum_ff + 23'(root_ff);
            end
            slot_in  = (32'(slot_ff) + 1 >= WINDOW) ? '0 : slot_ff + SW'(1);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!job_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         sum_ff   <= '0;
         slot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         sum_ff   <= sum_in;
         slot_ff  <= slot_in;
      end
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      cnt_ff  <= cnt_in;
   end

   // window store: read oldest during the root, write new magnitude at update
   always_ff @(posedge clock) begin
      old_rd_ff <= win_mem[slot_ff];
      if (state_ff == ST_WIN) win_mem[slot_ff] <= root_ff[16:0];
   end

   assign job_valid         = (state_ff == ST_OUT);
   assign job_data.neg      = neg_ff;
   assign job_data.mag_x    = mag_ff[0];
   assign job_data.mag_y    = mag_ff[1];
   assign job_data.mag_z    = mag_ff[2];
   assign job_data.fill     = fill_ff;
   assign job_data.sum      = sum_ff;

   a_fill_max: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= 7'(WINDOW)) else $error("fill count above window");
   a_fill_grow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WIN && fill_ff < 7'(WINDOW)) |=> fill_ff == $past(fill_ff) + 7'd1)
      else $error("fill count did not advance");
   a_root_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT && cnt_ff == 5'd0) |=> state_ff == ST_WIN)
      else $error("root did not finish");
endmodule
`default_nettype wire

/* sv/agn_queue.sv */
// Two-entry queue between front and back parts.
// Depends on agn_pkg.
`default_nettype none
module agn_queue import agn_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_stall,
   input  wire job_type in_data,
   output logic         out_valid,
   input  wire logic    out_stall,
   output job_type      out_data
);
   job_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_stall  = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && !in_stall;
   assign pop  = out_valid && !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end

   a_no_over: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'd2) else $error("queue overflow");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("queue count");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> wp_ff == rp_ff) else $error("queue ptrs");
endmodule
`default_nettype wire

/* sv/agn_back.sv */
// Back part: scales each axis in turn with shared multiply and restoring divide logic.
// Depends on agn_pkg.
`default_nettype none
module agn_back import agn_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic [15:0] gravity_ref,
   input  wire logic    job_valid,
   output logic         job_stall,
   input  wire job_type job_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);
   localparam int NW = 42;   // 2*mag*ref*fill + sum
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL1 = 3'd1;
   localparam logic [2:0] ST_MUL2 = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0]  state_ff, state_in;
   job_type     job_ff, job_in;
   logic [1:0]  axis_ff, axis_in;
   logic [32:0] prod_ff, prod_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [24:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [15:0] res_ff [3];
   logic [15:0] res_in [3];
   logic        zero_ff, zero_in;

   logic [16:0] mag;
   logic        neg;
   logic [24:0] rshift, dvs, rdiff;
   logic [15:0] sat;

   always_comb begin
      unique case (axis_ff)
         2'd0:    begin mag = job_ff.mag_x; neg = job_ff.neg[0]; end
         2'd1:    begin mag = job_ff.mag_y; neg = job_ff.neg[1]; end
         default: begin mag = job_ff.mag_z; neg = job_ff.neg[2]; end
      endcase
   end

   assign dvs    = {1'b0, job_ff.sum, 1'b0};
   assign rshift = {rem_ff[23:0], quo_ff[NW-1]};
   assign rdiff  = rshift - dvs;

   always_comb begin
      if (neg) sat = (quo_ff > NW'(32768)) ? 16'h8000 : 16'(-quo_ff[15:0]);
      else     sat = (quo_ff > NW'(32767)) ? 16'h7fff : quo_ff[15:0];
   end

   assign job_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      axis_in  = axis_ff;
      prod_in  = prod_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      res_in   = res_ff;
      zero_in  = zero_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_in   = job_data;
               axis_in  = '0;
               zero_in  = (job_data.sum == '0);
               state_in = (job_data.sum == '0) ? ST_OUT : ST_MUL1;
               for (int i = 0; i < 3; i++) res_in[i] = '0;
            end
         end
         ST_MUL1: begin
            prod_in  = 33'(mag * gravity_ref);
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            // 2*num + sum, then divide by 2*sum
            quo_in   = {1'b0, prod_ff * 40'(job_ff.fill), 1'b0} + NW'(job_ff.sum);
            rem_in   = '0;
            cnt_in   = 6'(NW);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == 6'd0) begin
               res_in[axis_ff] = sat;
               if (axis_ff == 2'd2) state_in = ST_OUT;
               else begin
                  axis_in  = axis_ff + 2'd1;
                  state_in = ST_MUL1;
               end
            end else begin
               if (!rdiff[24]) begin
                  rem_in = rdiff;
                  quo_in = {quo_ff[NW-2:0], 1'b1};
               end else begin
                  rem_in = rshift;
                  quo_in = {quo_ff[NW-2:0], 1'b0};
               end
               cnt_in = cnt_ff - 6'd1;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff  <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
      job_ff  <= job_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
      zero_ff <= zero_in;
   end

   assign rsp_valid             = (state_ff == ST_OUT);
   assign rsp_data.scaled_x     = res_ff[0];
   assign rsp_data.scaled_y     = res_ff[1];
   assign rsp_data.scaled_z     = res_ff[2];
   assign rsp_data.zero_average = zero_ff;

   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && zero_ff) |-> (res_ff[0] == '0 && res_ff[1] == '0 && res_ff[2] == '0))
      else $error("zero average with nonzero output");
   a_axis: assert property (@(posedge clock) disable iff (reset)
      axis_ff != 2'd3) else $error("bad axis");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("result dropped");
endmodule
`default_nettype wire

/* sv/accel_gravity_normalizer.sv */
// Top level of the accelerometer gravity normalizer.
// A sample first passes the front (18-step root, window update), then for each of the three axes
// the back runs multiply, multiply and divide, followed by the output state.
// The back part sets the throughput; the queue lets the front take a new sample while the back works.
// Synchronous reset clears window sum, fill count, slot, queue and gravity_ref=16384.
// Depends on agn_pkg, agn_front, agn_queue, agn_back.
`default_nettype none
module accel_gravity_normalizer import agn_pkg::*; #(
   parameter int WINDOW      = DEF_WINDOW
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data
);
   logic [15:0] gref_ff;
   logic        fj_valid, fj_stall, bj_valid, bj_stall;
   job_type     fj_data, bj_data;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) gref_ff <= GRAVITY_REF_RESET;
      else if (csr_valid) gref_ff <= csr_data;
   end

   agn_front #(.WINDOW(WINDOW)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .job_valid(fj_valid), .job_stall(fj_stall), .job_data(fj_data));

   agn_queue u_queue (
      .clock, .reset, .in_valid(fj_valid), .in_stall(fj_stall), .in_data(fj_data),
      .out_valid(bj_valid), .out_stall(bj_stall), .out_data(bj_data));

   agn_back u_back (
      .clock, .reset, .gravity_ref(gref_ff),
      .job_valid(bj_valid), .job_stall(bj_stall), .job_data(bj_data),
      .rsp_valid, .rsp_stall, .rsp_data);
endmodule
`default_nettype wire
